// ----- hdl/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg: shared definitions of the LED strip pixel serializer
// Field widths, command codes, register map and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lps_pkg;

	// payload field widths
	localparam int CMD_W         = 3;
	localparam int INDEX_W       = 8;
	localparam int CHAN_W        = 8;
	localparam int PACKED_W      = 16;
	localparam int COLOR_W       = 15;
	localparam int COMP_W        = 5;
	localparam int PIXEL_COUNT_W = 9;

	// one pixel on the wire: start bit plus colour bits
	localparam int PIXEL_BITS = COLOR_W + 1;

	// default sizes
	localparam int DEFAULT_MAX_PIXELS    = 256;
	localparam int DEFAULT_HEADER_CLOCKS = 32;

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// register index, taken from paddr[2]
	localparam logic REG_PIXEL_COUNT = 1'b0;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WR_RGB    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WR_PACKED = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_START     = 3'd4;

endpackage

// ----- hdl/lps_if.sv -----
// ----------------------------------------------------------------------------
// lps_if: stream channels of the LED strip pixel serializer
// Command items in, one result per command out; valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lps_item_if;
	logic                         valid;
	logic                         ready;
	logic [lps_pkg::CMD_W-1:0]    cmd;
	logic [lps_pkg::INDEX_W-1:0]  pixel_index;
	logic [lps_pkg::CHAN_W-1:0]   red;
	logic [lps_pkg::CHAN_W-1:0]   green;
	logic [lps_pkg::CHAN_W-1:0]   blue;
	logic [lps_pkg::PACKED_W-1:0] packed_color;

	modport source (
		output valid, cmd, pixel_index, red, green, blue, packed_color,
		input  ready
	);
	modport sink (
		input  valid, cmd, pixel_index, red, green, blue, packed_color,
		output ready
	);
endinterface

interface lps_result_if;
	logic                        valid;
	logic                        ready;
	logic                        data_bit;
	logic                        clock_pulse;
	logic [lps_pkg::COLOR_W-1:0] read_color;
	logic                        busy_res;
	logic                        accepted;

	modport source (
		output valid, data_bit, clock_pulse, read_color, busy_res, accepted,
		input  ready
	);
	modport sink (
		input  valid, data_bit, clock_pulse, read_color, busy_res, accepted,
		output ready
	);
endinterface

// ----- hdl/lps_ram.sv -----
// ----------------------------------------------------------------------------
// lps_ram: generic RAM, one write port and two registered read ports
// Read data of a port updates only at edges where its enable is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lps_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             ren_a,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic             ren_b,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		if (ren_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (ren_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ----- hdl/led_strip_pixel_serializer.sv -----
// ----------------------------------------------------------------------------
// led_strip_pixel_serializer: pixel store and two-wire LED strip serializer
// Stores 5:5:5 pixels and sends frames of header, pixel and tail clocks.
// ----------------------------------------------------------------------------
// Usage:
//   items carries commands (tick, write rgb, write packed, read, start).
//   results returns one transaction per command: the serial data level and
//   clock pulse of this bit period, the colour on a read, the busy flag
//   after the command and whether it was accepted. Commands other than a
//   tick are refused while a frame is on the wire; each tick sends one bit.
//   pixel_count is to be written over APB while the block is idle (unchecked).
// Timing:
//   After its command is accepted, a result passes the decode stage, where
//   the pixel store read returns, and then the output register. One command
//   is taken per cycle while results.ready is high; the pixel store has one
//   read port for commands and one for the serializer, so reads never stall.
// Reset:
//   After arst_n releases, a clearing pass writes black into all
//   MAX_PIXELS entries, one per cycle; items.ready stays low until the pass
//   ends. Configuration writes are taken during the pass.
// Stall:
//   While results.ready is low the output register holds, the decode stage
//   fills, and items.ready then drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_strip_pixel_serializer #(
	parameter int MAX_PIXELS    = lps_pkg::DEFAULT_MAX_PIXELS,
	parameter int HEADER_CLOCKS = lps_pkg::DEFAULT_HEADER_CLOCKS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lps_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lps_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	lps_item_if.sink                       items,
	lps_result_if.source                   results
);

	import lps_pkg::*;

	// derived widths
	localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW  = $clog2(MAX_PIXELS + 1);
	localparam int EW  = (CW > PIXEL_COUNT_W) ? CW : PIXEL_COUNT_W;
	localparam int XW  = ((CW > INDEX_W) ? CW : INDEX_W) + 1;
	localparam int HW  = $clog2(HEADER_CLOCKS + 1);
	localparam int BW  = (HW > 5) ? HW : 5;
	localparam int BIW = $clog2(COLOR_W);

	// frame phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_PIXELS = 2'd2;
	localparam logic [1:0] PH_TAIL   = 2'd3;

	// configuration
	logic [PIXEL_COUNT_W-1:0] pixel_count_q;
	logic [EW-1:0]            pcount_x;
	logic [EW-1:0]            eff_x;
	logic [CW-1:0]            eff_count;

	// clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// frame state
	logic [1:0]    phase_q;
	logic [BW-1:0] bit_cnt_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] flen_q;

	// decode stage
	logic                v1_q;
	logic [CMD_W-1:0]    cmd_s1;
	logic [INDEX_W-1:0]  idx_s1;
	logic [COLOR_W-1:0]  color_s1;
	logic                fwd_hit_s1;
	logic [COLOR_W-1:0]  fwd_data_s1;

	// output register
	logic               vo_q;
	logic               data_q;
	logic               clkp_q;
	logic [COLOR_W-1:0] rd_q;
	logic               busy_q;
	logic               acc_q;

	// handshake
	logic item_acc;
	logic s1_move;

	// store ports
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [COLOR_W-1:0]    ram_wdata;
	logic [AW+INDEX_W-1:0] in_idx_ext;
	logic [AW+INDEX_W-1:0] s1_idx_ext;
	logic [COLOR_W-1:0]    rdata_a;
	logic [COLOR_W-1:0]    rdata_b;
	logic [COLOR_W-1:0]    in_color;
	logic                  item_we;

	// decode results
	logic               busy;
	logic               is_cmd;
	logic               refused;
	logic               in_range;
	logic [COLOR_W-1:0] stored_color;
	logic               nx_data;
	logic               nx_clkp;
	logic [COLOR_W-1:0] nx_rd;
	logic [1:0]         nx_phase;
	logic [BW-1:0]      nx_bit_cnt;
	logic [CW-1:0]      nx_ptr;
	logic [CW-1:0]      nx_flen;
	logic [BW-1:0]      bit_inc;
	logic [CW-1:0]      ptr_inc;
	logic [BIW-1:0]     bit_sel;

	// ------------------------------------------------------------------
	// APB register: write at access phase, read back the count
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PIXEL_COUNT) begin
			pixel_count_q <= pwdata[PIXEL_COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PIXEL_COUNT) begin
			prdata = APB_DATA_W'(pixel_count_q);
		end
	end

	// saturate the count to the store depth
	assign pcount_x  = EW'(pixel_count_q);
	assign eff_x     = (pcount_x > EW'(MAX_PIXELS)) ? EW'(MAX_PIXELS) : pcount_x;
	assign eff_count = eff_x[CW-1:0];

	// ------------------------------------------------------------------
	// Clearing pass after reset
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(MAX_PIXELS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Handshake: decode stage advances when the output register frees up
	// ------------------------------------------------------------------
	assign s1_move     = v1_q && (!vo_q || results.ready);
	assign items.ready = !clr_busy_q && (!v1_q || s1_move);
	assign item_acc    = items.valid && items.ready;

	// ------------------------------------------------------------------
	// Pixel store
	// ------------------------------------------------------------------
	assign in_idx_ext = {{AW{1'b0}}, items.pixel_index};
	assign s1_idx_ext = {{AW{1'b0}}, idx_s1};

	// pack the incoming colour once, at the input
	always_comb begin
		if (items.cmd == CMD_WR_RGB) begin
			in_color = {items.red[COMP_W-1:0], items.green[COMP_W-1:0],
				items.blue[COMP_W-1:0]};
		end else begin
			in_color = items.packed_color[COLOR_W-1:0];
		end
	end

	assign item_we = s1_move && !refused && in_range
		&& (cmd_s1 == CMD_WR_RGB || cmd_s1 == CMD_WR_PACKED);

	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = item_we;
			ram_waddr = s1_idx_ext[AW-1:0];
			ram_wdata = color_s1;
		end
	end

	lps_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (MAX_PIXELS)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.ren_a   (item_acc),
		.raddr_a (in_idx_ext[AW-1:0]),
		.rdata_a (rdata_a),
		.ren_b   (1'b1),
		.raddr_b (ptr_q[AW-1:0]),
		.rdata_b (rdata_b)
	);

	// ------------------------------------------------------------------
	// Decode stage register, with write forwarding into the read
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (item_acc) begin
			v1_q <= 1'b1;
		end else if (s1_move) begin
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			cmd_s1      <= items.cmd;
			idx_s1      <= items.pixel_index;
			color_s1    <= in_color;
			fwd_hit_s1  <= item_we && (idx_s1 == items.pixel_index);
			fwd_data_s1 <= color_s1;
		end
	end

	// ------------------------------------------------------------------
	// Command decode and serializer step
	// ------------------------------------------------------------------
	assign busy     = (phase_q != PH_IDLE);
	assign is_cmd   = (cmd_s1 == CMD_WR_RGB) || (cmd_s1 == CMD_WR_PACKED)
		|| (cmd_s1 == CMD_READ) || (cmd_s1 == CMD_START);
	assign refused  = is_cmd && busy;
	assign in_range = XW'(idx_s1) < XW'(eff_count);

	assign stored_color = fwd_hit_s1 ? fwd_data_s1 : rdata_a;
	assign bit_inc      = bit_cnt_q + 1'b1;
	assign ptr_inc      = ptr_q + 1'b1;
	assign bit_sel      = BIW'(COLOR_W - 1) - bit_cnt_q[BIW-1:0] + 1'b1;

	always_comb begin
		nx_data    = 1'b0;
		nx_clkp    = 1'b0;
		nx_rd      = '0;
		nx_phase   = phase_q;
		nx_bit_cnt = bit_cnt_q;
		nx_ptr     = ptr_q;
		nx_flen    = flen_q;
		if (!refused) begin
			case (cmd_s1)
				CMD_WR_RGB, CMD_WR_PACKED: begin
					// store write handled by the RAM port
				end
				CMD_READ: begin
					if (in_range) begin
						nx_rd = stored_color;
					end
				end
				CMD_START: begin
					nx_flen    = eff_count;
					nx_phase   = PH_HEADER;
					nx_bit_cnt = '0;
					nx_ptr     = '0;
				end
				default: begin
					// tick: send the next bit of the frame
					case (phase_q)
						PH_HEADER: begin
							nx_clkp    = 1'b1;
							nx_bit_cnt = bit_inc;
							if (bit_inc >= BW'(HEADER_CLOCKS)) begin
								nx_bit_cnt = '0;
								nx_ptr     = '0;
								nx_phase   = (flen_q == '0) ? PH_IDLE : PH_PIXELS;
							end
						end
						PH_PIXELS: begin
							nx_clkp    = 1'b1;
							nx_bit_cnt = bit_inc;
							if (bit_cnt_q == '0) begin
								nx_data = 1'b1;
							end else begin
								nx_data = rdata_b[bit_sel];
							end
							if (bit_inc >= BW'(PIXEL_BITS)) begin
								nx_bit_cnt = '0;
								nx_ptr     = ptr_inc;
								if (ptr_inc >= flen_q) begin
									nx_ptr   = '0;
									nx_phase = PH_TAIL;
								end
							end
						end
						PH_TAIL: begin
							nx_clkp = 1'b1;
							nx_ptr  = ptr_inc;
							if (ptr_inc >= flen_q) begin
								nx_ptr   = '0;
								nx_phase = PH_IDLE;
							end
						end
						default: begin
							// idle: no clock, no data
						end
					endcase
				end
			endcase
		end
	end

	// advance the frame state with the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			ptr_q     <= '0;
			flen_q    <= '0;
		end else if (s1_move) begin
			phase_q   <= nx_phase;
			bit_cnt_q <= nx_bit_cnt;
			ptr_q     <= nx_ptr;
			flen_q    <= nx_flen;
		end
	end

	// ------------------------------------------------------------------
	// Output register: hold while the receiver stalls
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (s1_move) begin
			vo_q <= 1'b1;
		end else if (results.ready) begin
			vo_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			data_q <= nx_data;
			clkp_q <= nx_clkp;
			rd_q   <= nx_rd;
			busy_q <= (nx_phase != PH_IDLE);
			acc_q  <= !refused;
		end
	end

	assign results.valid       = vo_q;
	assign results.data_bit    = data_q;
	assign results.clock_pulse = clkp_q;
	assign results.read_color  = rd_q;
	assign results.busy_res    = busy_q;
	assign results.accepted    = acc_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bit_cnt_q == '0 && ptr_q == '0)
		else $error("idle frame state holds a stale counter or pointer");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIXELS |-> ptr_q < flen_q)
		else $error("pixel pointer ran past the frame length");

	a_no_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && !clr_busy_q |-> phase_q == PH_IDLE)
		else $error("pixel store written while a frame is on the wire");

	a_refused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q && !acc_q |-> !clkp_q && rd_q == '0 && busy_q)
		else $error("refused command produced output");

	a_data_needs_clock: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q && data_q |-> clkp_q)
		else $error("data bit raised without a clock pulse");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LED strip pixel serializer
// Drives command transactions and APB writes to pixel_count, predicts every
// result from a behavioral copy of the pixel store and frame sequencer, and
// compares each result field by field. Directed steps cover the edge cases;
// random phases on small strips follow, then reads with the count at the store size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import lps_pkg::*;

	localparam int          CLK_PERIOD   = 10;
	localparam int          RESET_CYCLES = 7;
	localparam int unsigned CYCLE_LIMIT  = 1_500_000;
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int          MAX_PIX      = DEFAULT_MAX_PIXELS;
	localparam int          HDR_CLOCKS   = DEFAULT_HEADER_CLOCKS;

	// codes 5..7 are not defined and act as a tick
	localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

	localparam logic [APB_ADDR_W-1:0] PIXEL_COUNT_ADDR = {REG_PIXEL_COUNT, 2'b00};

	typedef enum logic [1:0] {SEND_IDLE, SEND_HEADER, SEND_PIXELS, SEND_TAIL} send_phase_t;
	typedef enum logic [1:0] {STEP_ITEM, STEP_CONFIG, STEP_FLUSH} step_kind_t;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [INDEX_W-1:0]  pixel_index;
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
		logic [PACKED_W-1:0] packed_color;
	} cmd_item_t;

	typedef struct packed {
		logic               data_bit;
		logic               clock_pulse;
		logic [COLOR_W-1:0] read_color;
		logic               busy_res;
		logic               accepted;
	} strip_result_t;

	typedef struct packed {
		step_kind_t    kind;
		cmd_item_t     item;
		logic          known;
		strip_result_t result;
	} stim_step_t;

	// results that can be read off directly: data, clock, colour, busy, accepted
	localparam strip_result_t RES_IDLE    = {1'b0, 1'b0, 15'h0000, 1'b0, 1'b1};
	localparam strip_result_t RES_STARTED = {1'b0, 1'b0, 15'h0000, 1'b1, 1'b1};
	localparam strip_result_t RES_REFUSED = {1'b0, 1'b0, 15'h0000, 1'b1, 1'b0};
	localparam strip_result_t RES_HDR_CLK = {1'b0, 1'b1, 15'h0000, 1'b1, 1'b1};

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	lps_item_if   item_bus ();
	lps_result_if result_bus ();

	led_strip_pixel_serializer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (item_bus),
		.results (result_bus)
	);

	// strip model state
	logic [COLOR_W-1:0]       pixel_mem [MAX_PIX];
	send_phase_t              phase;
	int unsigned              bit_cnt;
	int unsigned              pix_ptr;
	int unsigned              frame_len;
	logic [PIXEL_COUNT_W-1:0] pixel_count_reg;

	strip_result_t pending_results [$];
	stim_step_t    directed_steps [$];
	int unsigned   err_cnt    = 0;
	int unsigned   stim_items = 0;
	int unsigned   cycle_cnt  = 0;
	bit            src_calm   = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	// abort a hung run
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	function automatic int unsigned active_pixels();
		return (pixel_count_reg > MAX_PIX) ? MAX_PIX : pixel_count_reg;
	endfunction

	// apply one command to the strip model and return its result
	function automatic strip_result_t model_command(input cmd_item_t it);
		strip_result_t      res;
		logic               in_range;
		logic [COLOR_W-1:0] px;
		res = '0;
		res.accepted = 1'b1;
		in_range = (it.pixel_index < active_pixels());
		if (it.cmd >= CMD_WR_RGB && it.cmd <= CMD_START && phase != SEND_IDLE) begin
			res.accepted = 1'b0;
		end else begin
			case (it.cmd)
				CMD_WR_RGB: begin
					if (in_range)
						pixel_mem[it.pixel_index] = {it.red[COMP_W-1:0], it.green[COMP_W-1:0],
							it.blue[COMP_W-1:0]};
				end
				CMD_WR_PACKED: begin
					if (in_range)
						pixel_mem[it.pixel_index] = it.packed_color[COLOR_W-1:0];
				end
				CMD_READ: begin
					if (in_range)
						res.read_color = pixel_mem[it.pixel_index];
				end
				CMD_START: begin
					frame_len = active_pixels();
					phase = SEND_HEADER;
					bit_cnt = 0;
					pix_ptr = 0;
				end
				default: begin
					// tick: emit the next bit of the frame, if one is running
					case (phase)
						SEND_HEADER: begin
							res.clock_pulse = 1'b1;
							bit_cnt++;
							if (bit_cnt >= HDR_CLOCKS) begin
								bit_cnt = 0;
								pix_ptr = 0;
								phase = (frame_len == 0) ? SEND_IDLE : SEND_PIXELS;
							end
						end
						SEND_PIXELS: begin
							res.clock_pulse = 1'b1;
							if (bit_cnt == 0) begin
								res.data_bit = 1'b1;
							end else begin
								px = pixel_mem[pix_ptr];
								res.data_bit = px[COLOR_W - bit_cnt];
							end
							bit_cnt++;
							if (bit_cnt >= PIXEL_BITS) begin
								bit_cnt = 0;
								pix_ptr++;
								if (pix_ptr >= frame_len) begin
									pix_ptr = 0;
									phase = SEND_TAIL;
								end
							end
						end
						SEND_TAIL: begin
							res.clock_pulse = 1'b1;
							pix_ptr++;
							if (pix_ptr >= frame_len) begin
								pix_ptr = 0;
								phase = SEND_IDLE;
							end
						end
						default: ;
					endcase
				end
			endcase
		end
		res.busy_res = (phase != SEND_IDLE);
		return res;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// random command; during a frame mostly ticks, otherwise store traffic
	function automatic cmd_item_t random_cmd(input bit framing);
		cmd_item_t   it;
		int unsigned roll;
		int unsigned span;
		it.pixel_index  = INDEX_W'($urandom_range(0, 255));
		it.red          = CHAN_W'($urandom);
		it.green        = CHAN_W'($urandom);
		it.blue         = CHAN_W'($urandom);
		it.packed_color = PACKED_W'($urandom);
		span = active_pixels();
		roll = $urandom_range(0, 99);
		if (framing) begin
			if (roll < 70)
				it.cmd = CMD_TICK;
			else if (roll < 85)
				it.cmd = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
			else
				it.cmd = CMD_W'($urandom_range(CMD_WR_RGB, CMD_START));
		end else begin
			if (roll < 25)
				it.cmd = CMD_WR_RGB;
			else if (roll < 50)
				it.cmd = CMD_WR_PACKED;
			else if (roll < 80)
				it.cmd = CMD_READ;
			else if (roll < 90)
				it.cmd = CMD_TICK;
			else
				it.cmd = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
			if (span != 0 && $urandom_range(0, 4) != 0)
				it.pixel_index = INDEX_W'($urandom_range(0, span - 1));
		end
		return it;
	endfunction

	// offer one command and record its expected result once taken
	task automatic send_cmd(input cmd_item_t it, input logic known, input strip_result_t res);
		int unsigned   gap;
		strip_result_t predicted;
		gap = pick_gap(src_calm);
		@(negedge clk);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_bus.valid        <= 1'b1;
		item_bus.cmd          <= it.cmd;
		item_bus.pixel_index  <= it.pixel_index;
		item_bus.red          <= it.red;
		item_bus.green        <= it.green;
		item_bus.blue         <= it.blue;
		item_bus.packed_color <= it.packed_color;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		predicted = model_command(it);
		pending_results.push_back(known ? res : predicted);
		stim_items++;
		if (stim_items % 40 == 0)
			src_calm = ($urandom_range(0, 3) == 0);
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write of pixel_count, then read it back
	task automatic write_pixel_count(input logic [PIXEL_COUNT_W-1:0] count);
		logic [APB_DATA_W-1:0] wdata;
		wdata = $urandom;
		wdata[PIXEL_COUNT_W-1:0] = count;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PIXEL_COUNT_ADDR;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		pixel_count_reg = count;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== APB_DATA_W'(count)) begin
			$display("%0t ns: pixel_count readback mismatch, expected %0h, got %0h",
				$time, count, prdata);
			err_cnt++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_field(input string field, input logic [COLOR_W-1:0] want,
		input logic [COLOR_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			err_cnt++;
		end
	endtask

	task automatic add_step(input step_kind_t kind, input logic [CMD_W-1:0] cmd,
		input logic [INDEX_W-1:0] idx, input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
		input logic [CHAN_W-1:0] b, input logic [PACKED_W-1:0] pk, input logic known,
		input strip_result_t res);
		stim_step_t s;
		s.kind   = kind;
		s.item   = {cmd, idx, r, g, b, pk};
		s.known  = known;
		s.result = res;
		directed_steps.push_back(s);
	endtask

	// result receiver: random stalls, two long hold-offs, compare in order
	initial begin
		strip_result_t want;
		strip_result_t got;
		int unsigned   taken;
		int unsigned   stall_left;
		int unsigned   hold_left;
		bit            calm;
		result_bus.ready = 1'b0;
		taken = 0;
		stall_left = 0;
		hold_left = 0;
		calm = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_bus.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				result_bus.ready <= 1'b1;
			end
			@(posedge clk);
			if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
				taken++;
				if (taken % 50 == 0)
					calm = ($urandom_range(0, 3) == 0);
				// hold off long enough for the input side to back up
				if (taken == 300 || taken == 900)
					hold_left = 400;
				stall_left = pick_gap(calm);
				got = {result_bus.data_bit, result_bus.clock_pulse, result_bus.read_color,
					result_bus.busy_res, result_bus.accepted};
				if (pending_results.size() == 0) begin
					$display("%0t ns: unexpected result transaction, expected none, got %0h",
						$time, got);
					err_cnt++;
				end else begin
					want = pending_results.pop_front();
					check_field("data_bit", COLOR_W'(want.data_bit), COLOR_W'(got.data_bit));
					check_field("clock_pulse", COLOR_W'(want.clock_pulse),
						COLOR_W'(got.clock_pulse));
					check_field("read_color", want.read_color, got.read_color);
					check_field("busy_res", COLOR_W'(want.busy_res), COLOR_W'(got.busy_res));
					check_field("accepted", COLOR_W'(want.accepted), COLOR_W'(got.accepted));
				end
			end
		end
	end

	// stimulus
	initial begin
		cmd_item_t   it;
		logic        reconf;
		int unsigned roll;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		item_bus.valid        = 1'b0;
		item_bus.cmd          = CMD_TICK;
		item_bus.pixel_index  = '0;
		item_bus.red          = '0;
		item_bus.green        = '0;
		item_bus.blue         = '0;
		item_bus.packed_color = '0;
		foreach (pixel_mem[i])
			pixel_mem[i] = '0;
		phase = SEND_IDLE;
		bit_cnt = 0;
		pix_ptr = 0;
		frame_len = 0;
		pixel_count_reg = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// count 0 after reset: everything out of range, header-only frame
		add_step(STEP_ITEM, CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, RES_IDLE);
		add_step(STEP_ITEM, CMD_WR_RGB, 8'd0, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b1, RES_IDLE);
		add_step(STEP_ITEM, CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, RES_IDLE);
		add_step(STEP_ITEM, CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, RES_STARTED);
		// refused while the frame is running
		add_step(STEP_ITEM, CMD_WR_PACKED, 8'd0, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b1,
			RES_REFUSED);
		add_step(STEP_ITEM, CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, RES_REFUSED);
		add_step(STEP_ITEM, CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, RES_REFUSED);
		add_step(STEP_ITEM, CMD_WR_RGB, 8'd0, 8'h1F, 8'h1F, 8'h1F, 16'h0000, 1'b1, RES_REFUSED);
		add_step(STEP_ITEM, CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, RES_HDR_CLK);
		add_step(STEP_ITEM, CMD_UNKNOWN_HI, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		add_step(STEP_FLUSH, CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		// full strip: extreme indexes, packed bit 15 dropped, upper channel bits dropped
		add_step(STEP_CONFIG, CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'd256, 1'b0, '0);
		add_step(STEP_ITEM, CMD_WR_RGB, 8'd255, 8'hFF, 8'h00, 8'hFF, 16'h0000, 1'b0, '0);
		add_step(STEP_ITEM, CMD_READ, 8'd255, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1,
			{1'b0, 1'b0, 15'h7C1F, 1'b0, 1'b1});
		add_step(STEP_ITEM, CMD_WR_PACKED, 8'd0, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b0, '0);
		add_step(STEP_ITEM, CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1,
			{1'b0, 1'b0, 15'h7FFF, 1'b0, 1'b1});
		add_step(STEP_ITEM, CMD_WR_PACKED, 8'd1, 8'h00, 8'h00, 8'h00, 16'h8000, 1'b0, '0);
		add_step(STEP_ITEM, CMD_READ, 8'd1, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, RES_IDLE);
		add_step(STEP_ITEM, CMD_WR_RGB, 8'd2, 8'hE0, 8'hE0, 8'hE0, 16'h0000, 1'b0, '0);
		// shrink to 5: reads and writes past the end are dropped
		add_step(STEP_CONFIG, CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'd5, 1'b0, '0);
		add_step(STEP_ITEM, CMD_READ, 8'd255, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, RES_IDLE);
		add_step(STEP_ITEM, CMD_WR_PACKED, 8'd5, 8'h00, 8'h00, 8'h00, 16'h7FFF, 1'b0, '0);
		add_step(STEP_ITEM, CMD_READ, 8'd5, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, RES_IDLE);
		add_step(STEP_ITEM, CMD_WR_PACKED, 8'd4, 8'h00, 8'h00, 8'h00, 16'h5555, 1'b0, '0);
		// count changed mid-frame: the frame keeps the count latched at start
		add_step(STEP_ITEM, CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		add_step(STEP_ITEM, CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		add_step(STEP_CONFIG, CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'd1, 1'b0, '0);
		add_step(STEP_FLUSH, CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0);
		// count above the store size saturates
		add_step(STEP_CONFIG, CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 16'd511, 1'b0, '0);
		add_step(STEP_ITEM, CMD_READ, 8'd255, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1,
			{1'b0, 1'b0, 15'h7C1F, 1'b0, 1'b1});

		foreach (directed_steps[i]) begin
			case (directed_steps[i].kind)
				STEP_ITEM: begin
					send_cmd(directed_steps[i].item, directed_steps[i].known,
						directed_steps[i].result);
				end
				STEP_CONFIG: begin
					drain();
					write_pixel_count(directed_steps[i].item.packed_color[PIXEL_COUNT_W-1:0]);
				end
				default: begin
					while (phase != SEND_IDLE) send_cmd(random_cmd(1'b1), 1'b0, '0);
				end
			endcase
		end

		// random phases on short strips: fill, send a frame, read back
		stim_items = 0;
		while (stim_items < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 9);
			drain();
			write_pixel_count((roll < 7) ? PIXEL_COUNT_W'($urandom_range(0, 6))
				: PIXEL_COUNT_W'($urandom_range(7, 40)));
			repeat ($urandom_range(10, 50)) send_cmd(random_cmd(1'b0), 1'b0, '0);
			it = random_cmd(1'b0);
			it.cmd = CMD_START;
			send_cmd(it, 1'b0, '0);
			reconf = ($urandom_range(0, 7) == 0);
			while (phase != SEND_IDLE) begin
				if (reconf && $urandom_range(0, 9) == 0) begin
					drain();
					write_pixel_count(PIXEL_COUNT_W'($urandom_range(0, 300)));
					reconf = 1'b0;
				end
				send_cmd(random_cmd(1'b1), 1'b0, '0);
			end
			repeat ($urandom_range(3, 12)) begin
				it = random_cmd(1'b0);
				it.cmd = CMD_READ;
				send_cmd(it, 1'b0, '0);
			end
		end

		// reads across the whole store with the count at its top
		drain();
		write_pixel_count(9'd256);
		repeat (20) begin
			it = random_cmd(1'b0);
			it.cmd = CMD_READ;
			send_cmd(it, 1'b0, '0);
		end

		drain();
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
